[design/i2cmra_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the I2C register access master.
// No dependencies.
package i2cmra_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START_A,
      ST_START_B,
      ST_START_C,
      ST_ADDRW,
      ST_REG,
      ST_WDATA,
      ST_WAIT,
      ST_ADDRR,
      ST_RDATA,
      ST_STOP_A,
      ST_STOP_B
   } state_type;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_BYTE  = 2'd2
   } op_type;

   localparam logic [7:0] PHASE_TICKS_RESET = 8'd10;
   localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

endpackage

[design/i2c_master_register_access.sv]
`timescale 1ns / 1ps
// I2C register access master: one accepted item advances the sequencer once and
// yields one result item in the cycle after. Throughput is one item per cycle
// while results are taken; the sequencer update and the line decode sit between
// the state registers and the result register, which is held until taken.
// Synchronous reset: idle, no result pending, phase_ticks = 10.
// Depends on i2cmra_pkg.
module i2c_master_register_access (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  logic [6:0] req_dev_addr,
   input  logic [7:0] req_reg_addr,
   input  logic [7:0] req_length,
   input  logic       req_is_read,
   input  logic [7:0] req_data_byte,
   input  logic       req_sda_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_scl,
   output logic       rsp_sda,
   output logic [7:0] rsp_read_data,
   output logic       rsp_read_valid,
   output logic       rsp_need_byte,
   output logic       rsp_done_res,
   output logic       rsp_failed,
   output logic       rsp_busy_res,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_phase_ticks
);

   i2cmra_pkg::state_type st_ff, st_in;
   logic [3:0] bi_ff, bi_in;
   logic [7:0] sr_ff, sr_in;
   logic [7:0] bl_ff, bl_in;
   logic [7:0] tc_ff, tc_in;
   logic [6:0] ta_ff, ta_in;
   logic [7:0] ra_ff, ra_in;
   logic       rm_ff, rm_in;
   logic [7:0] pb_ff, pb_in;
   logic       pv_ff, pv_in;
   logic       hh_ff, hh_in;
   logic       fail_ff, fail_in;
   logic       rs_ff, rs_in;
   logic [7:0] phase_ticks_ff;

   logic       rsp_valid_ff;
   logic       scl_ff, sda_ff, rvalid_ff, need_ff, done_ff, failed_ff, busy_ff;
   logic [7:0] rdata_ff;

   logic       req_accept;
   logic [7:0] pt;
   logic [7:0] tc_sum;
   logic [7:0] bl_dec;
   logic [7:0] wr_left;
   logic       phase_end;
   logic       wr_next;
   logic       ev_rvalid, ev_done, ev_failed;
   logic [7:0] ev_rdata;
   logic       scl_in, sda_in;

   assign req_accept = req_valid && req_ready;
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign csr_ready  = 1'b1;

   // sequencer next state
   always_comb begin
      st_in     = st_ff;
      bi_in     = bi_ff;
      sr_in     = sr_ff;
      bl_in     = bl_ff;
      tc_in     = tc_ff;
      ta_in     = ta_ff;
      ra_in     = ra_ff;
      rm_in     = rm_ff;
      pb_in     = pb_ff;
      pv_in     = pv_ff;
      hh_in     = hh_ff;
      fail_in   = fail_ff;
      rs_in     = rs_ff;
      ev_rvalid = 1'b0;
      ev_rdata  = 8'd0;
      ev_done   = 1'b0;
      ev_failed = 1'b0;
      phase_end = 1'b0;
      wr_next   = 1'b0;
      wr_left   = bl_ff;
      pt        = (phase_ticks_ff == 8'd0) ? 8'd1 : phase_ticks_ff;
      tc_sum    = tc_ff + 8'd1;
      bl_dec    = bl_ff - 8'd1;

      if (req_accept) begin
         unique case (req_op)
            i2cmra_pkg::OP_START: begin
               if (st_ff == i2cmra_pkg::ST_IDLE) begin
                  ta_in   = req_dev_addr;
                  ra_in   = req_reg_addr;
                  bl_in   = req_length;
                  rm_in   = req_is_read;
                  fail_in = 1'b0;
                  rs_in   = 1'b0;
                  tc_in   = 8'd0;
                  st_in   = i2cmra_pkg::ST_START_B;
               end
            end
            i2cmra_pkg::OP_BYTE: begin
               if (st_ff != i2cmra_pkg::ST_IDLE) begin
                  pb_in = req_data_byte;
                  pv_in = 1'b1;
               end
            end
            i2cmra_pkg::OP_TICK: begin
               if (st_ff == i2cmra_pkg::ST_WAIT) begin
                  if (pv_ff) begin
                     pv_in = 1'b0;
                     tc_in = 8'd0;
                     st_in = i2cmra_pkg::ST_WDATA;
                     sr_in = pb_ff;
                     bi_in = 4'd0;
                     hh_in = 1'b0;
                  end
               end else if (st_ff != i2cmra_pkg::ST_IDLE) begin
                  if (tc_sum >= pt) begin
                     tc_in     = 8'd0;
                     phase_end = 1'b1;
                  end else begin
                     tc_in = tc_sum;
                  end
               end
            end
            default: ;
         endcase
      end

      if (phase_end) begin
         unique case (st_ff)
            i2cmra_pkg::ST_START_A: st_in = i2cmra_pkg::ST_START_B;
            i2cmra_pkg::ST_START_B: st_in = i2cmra_pkg::ST_START_C;
            i2cmra_pkg::ST_START_C: begin
               st_in = rs_ff ? i2cmra_pkg::ST_ADDRR : i2cmra_pkg::ST_ADDRW;
               sr_in = {ta_ff, rs_ff};
               bi_in = 4'd0;
               hh_in = 1'b0;
            end
            i2cmra_pkg::ST_STOP_A: st_in = i2cmra_pkg::ST_STOP_B;
            i2cmra_pkg::ST_STOP_B: begin
               st_in     = i2cmra_pkg::ST_IDLE;
               pv_in     = 1'b0;
               ev_done   = 1'b1;
               ev_failed = fail_ff;
            end
            default: begin
               if (!hh_ff) begin
                  hh_in = 1'b1;
               end else if (bi_ff < i2cmra_pkg::BITS_PER_BYTE) begin
                  if (st_ff == i2cmra_pkg::ST_RDATA) begin
                     sr_in = {sr_ff[6:0], req_sda_in};
                     if (bi_ff == 4'd7) begin
                        ev_rvalid = 1'b1;
                        ev_rdata  = {sr_ff[6:0], req_sda_in};
                     end
                  end else begin
                     sr_in = {sr_ff[6:0], 1'b0};
                  end
                  bi_in = bi_ff + 4'd1;
                  hh_in = 1'b0;
               end else begin
                  // acknowledge slot just ended
                  unique case (st_ff)
                     i2cmra_pkg::ST_ADDRW: begin
                        if (req_sda_in) begin
                           fail_in = 1'b1;
                           st_in   = i2cmra_pkg::ST_STOP_A;
                        end else begin
                           st_in = i2cmra_pkg::ST_REG;
                           sr_in = ra_ff;
                           bi_in = 4'd0;
                           hh_in = 1'b0;
                        end
                     end
                     i2cmra_pkg::ST_REG: begin
                        if (rm_ff) begin
                           rs_in = 1'b1;
                           st_in = i2cmra_pkg::ST_START_A;
                        end else begin
                           wr_next = 1'b1;
                        end
                     end
                     i2cmra_pkg::ST_WDATA: begin
                        if (req_sda_in) begin
                           fail_in = 1'b1;
                           st_in   = i2cmra_pkg::ST_STOP_A;
                        end else begin
                           bl_in   = bl_dec;
                           wr_left = bl_dec;
                           wr_next = 1'b1;
                        end
                     end
                     i2cmra_pkg::ST_ADDRR: begin
                        if (bl_ff == 8'd0) begin
                           fail_in = 1'b0;
                           st_in   = i2cmra_pkg::ST_STOP_A;
                        end else begin
                           st_in = i2cmra_pkg::ST_RDATA;
                           sr_in = 8'd0;
                           bi_in = 4'd0;
                           hh_in = 1'b0;
                        end
                     end
                     default: begin
                        bl_in = bl_dec;
                        if (bl_dec == 8'd0) begin
                           fail_in = 1'b0;
                           st_in   = i2cmra_pkg::ST_STOP_A;
                        end else begin
                           st_in = i2cmra_pkg::ST_RDATA;
                           sr_in = 8'd0;
                           bi_in = 4'd0;
                           hh_in = 1'b0;
                        end
                     end
                  endcase
               end
            end
         endcase
      end

      // next write byte: stop, load the pending byte, or wait for one
      if (wr_next) begin
         if (wr_left == 8'd0) begin
            fail_in = 1'b0;
            st_in   = i2cmra_pkg::ST_STOP_A;
         end else if (pv_ff) begin
            pv_in = 1'b0;
            st_in = i2cmra_pkg::ST_WDATA;
            sr_in = pb_ff;
            bi_in = 4'd0;
            hh_in = 1'b0;
         end else begin
            st_in = i2cmra_pkg::ST_WAIT;
         end
      end
   end

   // line levels after this item
   always_comb begin
      scl_in = 1'b1;
      sda_in = 1'b1;
      unique case (st_in)
         i2cmra_pkg::ST_START_A: begin scl_in = 1'b0; sda_in = 1'b1; end
         i2cmra_pkg::ST_START_C: begin scl_in = 1'b1; sda_in = 1'b0; end
         i2cmra_pkg::ST_STOP_A:  begin scl_in = 1'b0; sda_in = 1'b0; end
         i2cmra_pkg::ST_STOP_B:  begin scl_in = 1'b1; sda_in = 1'b0; end
         i2cmra_pkg::ST_WAIT:    begin scl_in = 1'b0; sda_in = 1'b1; end
         i2cmra_pkg::ST_ADDRW, i2cmra_pkg::ST_REG, i2cmra_pkg::ST_WDATA,
         i2cmra_pkg::ST_ADDRR, i2cmra_pkg::ST_RDATA: begin
            scl_in = hh_in;
            if (bi_in >= i2cmra_pkg::BITS_PER_BYTE) begin
               // master ACKs all read bytes but the last
               sda_in = !(st_in == i2cmra_pkg::ST_RDATA && bl_in > 8'd1);
            end else if (st_in == i2cmra_pkg::ST_RDATA) begin
               sda_in = 1'b1;
            end else begin
               sda_in = sr_in[7];
            end
         end
         default: begin scl_in = 1'b1; sda_in = 1'b1; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff          <= i2cmra_pkg::ST_IDLE;
         bi_ff          <= 4'd0;
         sr_ff          <= 8'd0;
         bl_ff          <= 8'd0;
         tc_ff          <= 8'd0;
         ta_ff          <= 7'd0;
         ra_ff          <= 8'd0;
         rm_ff          <= 1'b0;
         pb_ff          <= 8'd0;
         pv_ff          <= 1'b0;
         hh_ff          <= 1'b0;
         fail_ff        <= 1'b0;
         rs_ff          <= 1'b0;
         phase_ticks_ff <= i2cmra_pkg::PHASE_TICKS_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         st_ff   <= st_in;
         bi_ff   <= bi_in;
         sr_ff   <= sr_in;
         bl_ff   <= bl_in;
         tc_ff   <= tc_in;
         ta_ff   <= ta_in;
         ra_ff   <= ra_in;
         rm_ff   <= rm_in;
         pb_ff   <= pb_in;
         pv_ff   <= pv_in;
         hh_ff   <= hh_in;
         fail_ff <= fail_in;
         rs_ff   <= rs_in;
         if (csr_valid && csr_ready) begin
            phase_ticks_ff <= csr_phase_ticks;
         end
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result register, loaded once per accepted item
   always_ff @(posedge clock) begin
      if (req_accept) begin
         scl_ff    <= scl_in;
         sda_ff    <= sda_in;
         rdata_ff  <= ev_rdata;
         rvalid_ff <= ev_rvalid;
         need_ff   <= (st_in == i2cmra_pkg::ST_WAIT) && !pv_in;
         done_ff   <= ev_done;
         failed_ff <= ev_failed;
         busy_ff   <= (st_in != i2cmra_pkg::ST_IDLE);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl        = scl_ff;
   assign rsp_sda        = sda_ff;
   assign rsp_read_data  = rdata_ff;
   assign rsp_read_valid = rvalid_ff;
   assign rsp_need_byte  = need_ff;
   assign rsp_done_res   = done_ff;
   assign rsp_failed     = failed_ff;
   assign rsp_busy_res   = busy_ff;

endmodule
